[sv/frag_pkg.sv]
`timescale 1ns / 1ps

package frag_pkg;

    localparam int POS_W      = 17;
    localparam int OFF_W      = 18;
    localparam int LEN_W      = 17;
    localparam int OP_ADDR_W  = 12;
    localparam int NUM_SLOTS  = 5;
    localparam int STATUS_SLOT = 4;
    localparam int HELD_BYTES = 3;
    localparam int LEN_ADJ    = 3;

    localparam logic [POS_W-1:0] POS_CAP = '1;

    localparam logic [7:0] SYNC_A = 8'hAB;
    localparam logic [7:0] SYNC_B = 8'hEA;
    localparam logic [7:0] TAG_A  = 8'hFE;
    localparam logic [7:0] TAG_B  = 8'hFF;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_STATUS
    } op_kind_t;

    typedef struct packed {
        op_kind_t               kind;
        logic [OP_ADDR_W-1:0]   addr;
        logic [7:0]             data;
        logic                   in_range;
        logic                   complete;
        logic [LEN_W-1:0]       exp_len;
        logic                   ovf;
    } frag_op_t;

endpackage

[sv/fragment_packet_reassembler_core.sv]
`timescale 1ns / 1ps
// Channel | Handshake             | Payload
// --------+-----------------------+------------------------------------------------
// request | req_valid / req_ready | kind, data_byte, first_in_write, last_in_write,
//         |                       | read_address
// response| rsp_valid / rsp_ready | is_read_reply, read_data, packet_complete,
//         |                       | expected_length, overflow
//
// One item per cycle while each item needs at most one queue operation and the queue has
// room; the back end retires one operation (buffer write, buffer read or status) per cycle
// on its single memory port while no response is stalled, so byte 3 of a write needs up
// to 5 operations, the end of a short write up to 3, and any last byte adds its status.
// Reset clears control state only; the packet buffer is not cleared.
// A stalled response holds the queue, which then holds the request side.

module fragment_packet_reassembler_core import frag_pkg::*; #(
    parameter int BUFFER_DEPTH        = 512,
    parameter int FIRST_FRAGMENT_SIZE = 20,
    parameter int FRAGMENT_PAYLOAD    = 19,
    parameter int QUEUE_DEPTH         = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic              kind,
    input  logic [7:0]        data_byte,
    input  logic              first_in_write,
    input  logic              last_in_write,
    input  logic [8:0]        read_address,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output logic              is_read_reply,
    output logic [7:0]        read_data,
    output logic              packet_complete,
    output logic [LEN_W-1:0]  expected_length,
    output logic              overflow
);

    logic     fq_valid, fq_ready;
    frag_op_t fq_op;
    logic     qb_valid, qb_ready;
    frag_op_t qb_op;

    frag_front #(
        .BUFFER_DEPTH        (BUFFER_DEPTH),
        .FIRST_FRAGMENT_SIZE (FIRST_FRAGMENT_SIZE),
        .FRAGMENT_PAYLOAD    (FRAGMENT_PAYLOAD)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .kind           (kind),
        .data_byte      (data_byte),
        .first_in_write (first_in_write),
        .last_in_write  (last_in_write),
        .read_address   (read_address),
        .op_valid       (fq_valid),
        .op             (fq_op),
        .op_ready       (fq_ready)
    );

    frag_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_op    (fq_op),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_op     (qb_op)
    );

    frag_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .op_valid        (qb_valid),
        .op_ready        (qb_ready),
        .op              (qb_op),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .is_read_reply   (is_read_reply),
        .read_data       (read_data),
        .packet_complete (packet_complete),
        .expected_length (expected_length),
        .overflow        (overflow)
    );

endmodule

[sv/frag_front.sv]
`timescale 1ns / 1ps

module frag_front import frag_pkg::*; #(
    parameter int BUFFER_DEPTH        = 512,
    parameter int FIRST_FRAGMENT_SIZE = 20,
    parameter int FRAGMENT_PAYLOAD    = 19
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic        kind,
    input  logic [7:0]  data_byte,
    input  logic        first_in_write,
    input  logic        last_in_write,
    input  logic [8:0]  read_address,
    output logic        op_valid,
    output frag_op_t    op,
    input  logic        op_ready
);

    logic [POS_W-1:0]     byte_pos_reg, byte_pos_next;
    logic                 is_cont_reg, is_cont_next;
    logic [OFF_W-1:0]     frag_base_reg, frag_base_next;
    logic [7:0]           held_reg [HELD_BYTES];
    logic [7:0]           held_next [HELD_BYTES];
    logic                 ovf_reg, ovf_next;
    logic [LEN_W-1:0]     exp_len_reg, exp_len_next;
    logic [NUM_SLOTS-1:0] pend_valid_reg, pend_valid_next;
    frag_op_t             pend_op_reg [NUM_SLOTS];

    logic [POS_W-1:0]     p;
    logic [OFF_W-1:0]     p_ext;
    logic [OFF_W-1:0]     base;
    logic                 hdr;
    logic [OFF_W-1:0]     cand_off [STATUS_SLOT];
    logic [7:0]           cand_data [STATUS_SLOT];
    logic [STATUS_SLOT-1:0] cand_use;
    logic [STATUS_SLOT-1:0] write_ok;
    logic                 drop;
    logic                 complete;
    frag_op_t             new_op [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] new_mask;
    logic [$clog2(NUM_SLOTS)-1:0] sel;
    logic                 accept;
    logic                 pop;

    always_comb
    begin
        p = first_in_write ? '0 : byte_pos_reg;
        p_ext = OFF_W'(p);
        held_next = held_reg;
        if (p < POS_W'(HELD_BYTES))
        begin
            held_next[p[1:0]] = data_byte;
        end
        base = OFF_W'(FIRST_FRAGMENT_SIZE) + OFF_W'(held_next[0]) * OFF_W'(FRAGMENT_PAYLOAD);
        hdr = (p == POS_W'(HELD_BYTES))
            && (held_reg[0] == SYNC_A || held_reg[0] == SYNC_B)
            && (data_byte == TAG_A || data_byte == TAG_B);

        for (int i = 0; i < STATUS_SLOT; i++)
        begin
            cand_off[i]  = '0;
            cand_data[i] = '0;
        end
        cand_use = '0;

        if (p == POS_W'(HELD_BYTES))
        begin
            if (hdr)
            begin
                cand_use = 4'b1111;
                cand_off[0] = OFF_W'(0);
                cand_off[1] = OFF_W'(1);
                cand_off[2] = OFF_W'(2);
                cand_off[3] = OFF_W'(3);
                cand_data[0] = held_reg[0];
                cand_data[1] = held_reg[1];
                cand_data[2] = held_reg[2];
                cand_data[3] = data_byte;
            end
            else
            begin
                cand_use = 4'b0111;
                cand_off[0] = base;
                cand_off[1] = base + OFF_W'(1);
                cand_off[2] = base + OFF_W'(2);
                cand_data[0] = held_reg[1];
                cand_data[1] = held_reg[2];
                cand_data[2] = data_byte;
            end
        end
        else if (p > POS_W'(HELD_BYTES))
        begin
            cand_use[0] = 1'b1;
            cand_off[0] = is_cont_reg ? (frag_base_reg + p_ext - OFF_W'(1)) : p_ext;
            cand_data[0] = data_byte;
        end
        else if (last_in_write)
        begin
            cand_use[0] = (p >= POS_W'(1));
            cand_use[1] = (p >= POS_W'(2));
            cand_off[0] = base;
            cand_off[1] = base + OFF_W'(1);
            cand_data[0] = held_next[1];
            cand_data[1] = held_next[2];
        end

        drop = 1'b0;
        for (int i = 0; i < STATUS_SLOT; i++)
        begin
            write_ok[i] = cand_use[i] && (cand_off[i] < OFF_W'(BUFFER_DEPTH));
            drop = drop | (cand_use[i] && !write_ok[i]);
        end
        ovf_next = ((p == '0) ? 1'b0 : ovf_reg) | drop;

        is_cont_next   = is_cont_reg;
        frag_base_next = frag_base_reg;
        exp_len_next   = exp_len_reg;
        if (p == POS_W'(HELD_BYTES))
        begin
            is_cont_next = !hdr;
            if (hdr)
            begin
                exp_len_next = LEN_W'({held_reg[1], held_reg[2]}) + LEN_W'(LEN_ADJ);
            end
            else
            begin
                frag_base_next = base;
            end
        end
        else if (p < POS_W'(HELD_BYTES) && last_in_write)
        begin
            is_cont_next   = 1'b1;
            frag_base_next = base;
        end

        if (is_cont_next)
        begin
            complete = OFF_W'(exp_len_next) <= frag_base_next + p_ext;
        end
        else
        begin
            complete = OFF_W'(exp_len_next) <= p_ext + OFF_W'(1);
        end

        if (last_in_write)
        begin
            byte_pos_next = '0;
        end
        else if (p == POS_CAP)
        begin
            byte_pos_next = p;
        end
        else
        begin
            byte_pos_next = p + POS_W'(1);
        end

        for (int i = 0; i < STATUS_SLOT; i++)
        begin
            new_op[i].kind     = OP_WRITE;
            new_op[i].addr     = cand_off[i][OP_ADDR_W-1:0];
            new_op[i].data     = cand_data[i];
            new_op[i].in_range = 1'b1;
            new_op[i].complete = 1'b0;
            new_op[i].exp_len  = '0;
            new_op[i].ovf      = 1'b0;
        end
        new_op[STATUS_SLOT].data = '0;
        if (kind)
        begin
            new_op[STATUS_SLOT].kind     = OP_READ;
            new_op[STATUS_SLOT].addr     = OP_ADDR_W'(read_address);
            new_op[STATUS_SLOT].in_range = OFF_W'(read_address) < OFF_W'(BUFFER_DEPTH);
            new_op[STATUS_SLOT].complete = 1'b0;
            new_op[STATUS_SLOT].exp_len  = '0;
            new_op[STATUS_SLOT].ovf      = 1'b0;
            new_mask = NUM_SLOTS'(1) << STATUS_SLOT;
        end
        else
        begin
            new_op[STATUS_SLOT].kind     = OP_STATUS;
            new_op[STATUS_SLOT].addr     = '0;
            new_op[STATUS_SLOT].in_range = 1'b0;
            new_op[STATUS_SLOT].complete = complete;
            new_op[STATUS_SLOT].exp_len  = exp_len_next;
            new_op[STATUS_SLOT].ovf      = ovf_next;
            new_mask = {last_in_write, write_ok};
        end

        sel = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (pend_valid_reg[i])
            begin
                sel = ($clog2(NUM_SLOTS))'(i);
            end
        end
        op_valid = |pend_valid_reg;
        op = pend_op_reg[sel];
        pop = op_valid && op_ready;

        req_ready = (pend_valid_reg == '0)
            || (((pend_valid_reg & (pend_valid_reg - NUM_SLOTS'(1))) == '0) && op_ready);
        accept = req_valid && req_ready;

        pend_valid_next = pend_valid_reg;
        if (accept)
        begin
            pend_valid_next = new_mask;
        end
        else if (pop)
        begin
            pend_valid_next[sel] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= '0;
            byte_pos_reg   <= '0;
            is_cont_reg    <= 1'b0;
            frag_base_reg  <= '0;
            ovf_reg        <= 1'b0;
            exp_len_reg    <= '0;
            for (int i = 0; i < HELD_BYTES; i++)
            begin
                held_reg[i] <= '0;
            end
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            if (accept && !kind)
            begin
                byte_pos_reg  <= byte_pos_next;
                is_cont_reg   <= is_cont_next;
                frag_base_reg <= frag_base_next;
                ovf_reg       <= ovf_next;
                exp_len_reg   <= exp_len_next;
                held_reg      <= held_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_op_reg <= new_op;
        end
    end

endmodule

[sv/frag_queue.sv]
`timescale 1ns / 1ps

module frag_queue import frag_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  frag_op_t push_op,
    output logic     pop_valid,
    input  logic     pop_ready,
    output frag_op_t pop_op
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    frag_op_t         entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             push;
    logic             pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_op     = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

[sv/frag_back.sv]
`timescale 1ns / 1ps

module frag_back import frag_pkg::*; #(
    parameter int BUFFER_DEPTH = 512
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             op_valid,
    output logic             op_ready,
    input  frag_op_t         op,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output logic             is_read_reply,
    output logic [7:0]       read_data,
    output logic             packet_complete,
    output logic [LEN_W-1:0] expected_length,
    output logic             overflow
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic [7:0] packet_buffer [BUFFER_DEPTH];
    logic [7:0] rdata_reg;
    logic       rsp_valid_reg;
    frag_op_t   rsp_op_reg;
    logic       pop;
    logic       has_result;

    assign op_ready   = !rsp_valid_reg || rsp_ready;
    assign pop        = op_valid && op_ready;
    assign has_result = op.kind != OP_WRITE;

    always_ff @(posedge clk)
    begin
        if (pop && op.kind == OP_WRITE)
        begin
            packet_buffer[op.addr[AW-1:0]] <= op.data;
        end
        if (pop && op.kind == OP_READ && op.in_range)
        begin
            rdata_reg <= packet_buffer[op.addr[AW-1:0]];
        end
        if (pop && has_result)
        begin
            rsp_op_reg <= op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (op_ready)
        begin
            rsp_valid_reg <= pop && has_result;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign is_read_reply   = rsp_op_reg.kind == OP_READ;
    assign read_data       = (is_read_reply && rsp_op_reg.in_range) ? rdata_reg : 8'd0;
    assign packet_complete = rsp_op_reg.complete;
    assign expected_length = rsp_op_reg.exp_len;
    assign overflow        = rsp_op_reg.ovf;

endmodule

[sv/frag_checker.sv]
`timescale 1ns / 1ps

module frag_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        is_read_reply,
    input logic [7:0]  read_data,
    input logic        packet_complete,
    input logic [16:0] expected_length,
    input logic        overflow
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(is_read_reply)
            && $stable(read_data) && $stable(packet_complete)
            && $stable(expected_length) && $stable(overflow))
        else $error("response dropped or changed while stalled");

    a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && is_read_reply |-> !packet_complete && expected_length == 17'd0
            && !overflow)
        else $error("read reply carries status bits");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !is_read_reply |-> read_data == 8'd0)
        else $error("write status carries read data");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !is_read_reply |-> expected_length <= 17'd65538)
        else $error("expected length out of range");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !rsp_valid)
        else $error("response valid during reset");

endmodule

bind fragment_packet_reassembler_core frag_checker u_frag_checker (.*);
